// ===== hw/rtl/vsa_pkg.sv =====
package vsa_pkg;

  localparam int unsigned OP_W   = 4;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned ADDR_W = 15;
  localparam int unsigned BUS_W  = 14;

  localparam logic [ADDR_W-1:0] BUS_MASK      = 15'h3FFF;
  localparam logic [ADDR_W-1:0] X_BITS        = 15'h041F;
  localparam logic [ADDR_W-1:0] Y_BITS        = 15'h7BE0;
  localparam logic [ADDR_W-1:0] SCROLL_Y_KEEP = 15'h0C1F;
  localparam logic [7:0]        ROW_WRAP      = 8'hF0;
  localparam logic [ADDR_W-1:0] ROW_STEP      = 15'd32;
  localparam logic [ADDR_W-1:0] COL_STEP      = 15'd1;

  typedef enum logic [OP_W-1:0] {
    OP_CTRL   = 4'd0,
    OP_SCROLL = 4'd1,
    OP_ADDR   = 4'd2,
    OP_DATA   = 4'd3,
    OP_STATUS = 4'd4,
    OP_X_STEP = 4'd5,
    OP_Y_STEP = 4'd6,
    OP_COPY_X = 4'd7,
    OP_COPY_Y = 4'd8
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] data_byte;
    logic              rendering_active;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] access_address;
    logic [ADDR_W-1:0] current_address;
    logic [BUS_W-1:0]  tile_fetch_address;
    logic [BUS_W-1:0]  attribute_fetch_address;
    logic [2:0]        attribute_shift;
    logic [2:0]        fine_x_out;
    logic [2:0]        fine_y_out;
    logic              second_write_next;
  } result_t;

  function automatic logic [ADDR_W-1:0] coarse_x_step(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] r;
    r = a;
    if (a[4:0] == 5'd31) begin
      r[4:0] = 5'd0;
      r[10]  = ~a[10];
    end else begin
      r[4:0] = a[4:0] + 5'd1;
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] fine_y_step(input logic [ADDR_W-1:0] a);
    logic [7:0] sy;
    logic       flip;
    sy   = {a[9:5], a[14:12]} + 8'd1;
    flip = (sy == ROW_WRAP);
    if (flip) begin
      sy = 8'd0;
    end
    return ((a & SCROLL_Y_KEEP) ^ {3'd0, flip, 11'd0}) | {sy[2:0], 2'b00, sy[7:3], 5'd0};
  endfunction

endpackage

// ===== hw/rtl/vsa_in_stage.sv =====
module vsa_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  vsa_pkg::item_t  item_in,
  input  logic            advance,
  output logic            item_vld,
  output vsa_pkg::item_t  item
);

  logic           vld_r;
  vsa_pkg::item_t item_r;
  logic           load;

  assign load     = advance || !vld_r;
  assign in_stall = !load;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= item_in;
    end
  end

endmodule

// ===== hw/rtl/vsa_core.sv =====
module vsa_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  vsa_pkg::item_t   item,
  output vsa_pkg::result_t res
);

  logic [vsa_pkg::ADDR_W-1:0] cur_r, cur_nxt;
  logic [vsa_pkg::ADDR_W-1:0] tmp_r, tmp_nxt;
  logic [2:0]                 fine_x_r, fine_x_nxt;
  logic                       latch_r, latch_nxt;
  logic                       row_r, row_nxt;
  logic [vsa_pkg::DATA_W-1:0] d;

  assign d = item.data_byte;

  always_comb begin
    cur_nxt    = cur_r;
    tmp_nxt    = tmp_r;
    fine_x_nxt = fine_x_r;
    latch_nxt  = latch_r;
    row_nxt    = row_r;
    unique case (item.op)
      vsa_pkg::OP_CTRL: begin
        tmp_nxt = {tmp_r[14:12], d[1:0], tmp_r[9:0]};
        row_nxt = d[2];
      end
      vsa_pkg::OP_SCROLL: begin
        if (latch_r) begin
          tmp_nxt   = {d[2:0], tmp_r[11:10], d[7:3], tmp_r[4:0]};
          latch_nxt = 1'b0;
        end else begin
          fine_x_nxt = d[2:0];
          tmp_nxt    = {tmp_r[14:5], d[7:3]};
          latch_nxt  = 1'b1;
        end
      end
      vsa_pkg::OP_ADDR: begin
        if (latch_r) begin
          tmp_nxt   = {tmp_r[14:8], d};
          cur_nxt   = {tmp_r[14:8], d};
          latch_nxt = 1'b0;
        end else begin
          tmp_nxt   = {1'b0, d[5:0], tmp_r[7:0]};
          latch_nxt = 1'b1;
        end
      end
      vsa_pkg::OP_DATA: begin
        if (item.rendering_active) begin
          cur_nxt = vsa_pkg::fine_y_step(vsa_pkg::coarse_x_step(cur_r));
        end else begin
          cur_nxt = (cur_r + (row_r ? vsa_pkg::ROW_STEP : vsa_pkg::COL_STEP))
                    & vsa_pkg::BUS_MASK;
        end
      end
      vsa_pkg::OP_STATUS: begin
        latch_nxt = 1'b0;
      end
      vsa_pkg::OP_X_STEP: begin
        cur_nxt = vsa_pkg::coarse_x_step(cur_r);
      end
      vsa_pkg::OP_Y_STEP: begin
        cur_nxt = vsa_pkg::fine_y_step(cur_r);
      end
      vsa_pkg::OP_COPY_X: begin
        cur_nxt = (cur_r & vsa_pkg::Y_BITS) | (tmp_r & vsa_pkg::X_BITS);
      end
      vsa_pkg::OP_COPY_Y: begin
        cur_nxt = (cur_r & vsa_pkg::X_BITS) | (tmp_r & vsa_pkg::Y_BITS);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.access_address          = cur_r;
    res.current_address         = cur_nxt;
    res.tile_fetch_address      = {2'b10, cur_nxt[11:0]};
    res.attribute_fetch_address = {2'b10, cur_nxt[11:10], 4'b1111, cur_nxt[9:7],
                                   cur_nxt[4:2]};
    res.attribute_shift         = {cur_nxt[6], cur_nxt[1], 1'b0};
    res.fine_x_out              = fine_x_nxt;
    res.fine_y_out              = cur_nxt[14:12];
    res.second_write_next       = latch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      tmp_r    <= '0;
      fine_x_r <= '0;
      latch_r  <= 1'b0;
      row_r    <= 1'b0;
    end else if (step) begin
      cur_r    <= cur_nxt;
      tmp_r    <= tmp_nxt;
      fine_x_r <= fine_x_nxt;
      latch_r  <= latch_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

// ===== hw/rtl/vsa_out_stage.sv =====
module vsa_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_vld,
  input  vsa_pkg::result_t res,
  input  logic             out_stall,
  output logic             advance,
  output logic             out_valid,
  output vsa_pkg::result_t res_out
);

  logic             vld_r;
  vsa_pkg::result_t res_r;

  assign advance   = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= item_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_vld) begin
      res_r <= res;
    end
  end

endmodule

// ===== hw/rtl/video_scroll_address_unit.sv =====
// The input register takes a transaction; the result register feeds the out_ ports.
// Throughput: one transaction per cycle; the input register and the result register
// each advance whenever the result register is empty or being taken.
// Reset: synchronous active-low rst_n clears both valid flags and the scroll state
// (current and temporary address, fine X, write toggle, increment flag).
module video_scroll_address_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [vsa_pkg::OP_W-1:0]     in_op,
  input  logic [vsa_pkg::DATA_W-1:0]   in_data_byte,
  input  logic                         in_rendering_active,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [vsa_pkg::ADDR_W-1:0]   out_access_address,
  output logic [vsa_pkg::ADDR_W-1:0]   out_current_address,
  output logic [vsa_pkg::BUS_W-1:0]    out_tile_fetch_address,
  output logic [vsa_pkg::BUS_W-1:0]    out_attribute_fetch_address,
  output logic [2:0]                   out_attribute_shift,
  output logic [2:0]                   out_fine_x_out,
  output logic [2:0]                   out_fine_y_out,
  output logic                         out_second_write_next
);

  vsa_pkg::item_t   item_in;
  vsa_pkg::item_t   item;
  vsa_pkg::result_t res;
  vsa_pkg::result_t res_out;
  logic             item_vld;
  logic             advance;

  assign item_in.op               = in_op;
  assign item_in.data_byte        = in_data_byte;
  assign item_in.rendering_active = in_rendering_active;

  vsa_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .item_in  (item_in),
    .advance  (advance),
    .item_vld (item_vld),
    .item     (item)
  );

  vsa_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (item_vld && advance),
    .item  (item),
    .res   (res)
  );

  vsa_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .res       (res),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .res_out   (res_out)
  );

  assign out_access_address          = res_out.access_address;
  assign out_current_address         = res_out.current_address;
  assign out_tile_fetch_address      = res_out.tile_fetch_address;
  assign out_attribute_fetch_address = res_out.attribute_fetch_address;
  assign out_attribute_shift         = res_out.attribute_shift;
  assign out_fine_x_out              = res_out.fine_x_out;
  assign out_fine_y_out              = res_out.fine_y_out;
  assign out_second_write_next       = res_out.second_write_next;

endmodule
